@@ rtl/plh_pkg.sv @@
// Package for the photon lifetime histogrammer: defaults, request, status and register codes.
`timescale 1ns / 1ps

package plh_pkg;

  localparam int NATIVE_BINS_DEF  = 256;
  localparam int CHANNELS_DEF     = 4;
  localparam int MAX_BINNED_X_DEF = 16;
  localparam int MAX_BINNED_Y_DEF = 16;
  localparam int MAX_PLANES_DEF   = 1;

  localparam logic [1:0] REQ_PHOTON = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE  = 3'd2;
  localparam logic [2:0] ST_BAD_BIN  = 3'd3;
  localparam logic [2:0] ST_BAD_READ = 3'd4;

  typedef enum logic [2:0] {
    CFG_SENSOR_WIDTH,
    CFG_SENSOR_HEIGHT,
    CFG_PLANE_COUNT,
    CFG_BIN_FACTOR,
    CFG_REPETITION,
    CFG_DOWNSAMPLE,
    CFG_CHANNEL_MASK,
    CFG_TIME_SHIFTS
  } cfg_reg_t;

  localparam logic [8:0]  SENSOR_WIDTH_RST  = 9'd16;
  localparam logic [8:0]  SENSOR_HEIGHT_RST = 9'd16;
  localparam logic        PLANE_COUNT_RST   = 1'b1;
  localparam logic [4:0]  BIN_FACTOR_RST    = 5'd1;
  localparam logic [3:0]  CHANNEL_MASK_RST  = 4'hf;

endpackage

@@ rtl/plh_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module plh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/photon_lifetime_histogrammer_unit.sv @@
// Photon lifetime histogrammer: per-pixel, per-channel arrival-time histogram in one RAM.
//
// One request is handled at a time. A counted photon passes through a two-bit-per-cycle
// restoring divider (binned x, binned y and the period wrap run side by side), then
// evaluation, a RAM read, the saturating write-back and loading of the result register.
// A photon that is turned away skips the RAM. A clear request, and reset, start a
// clearing pass over the store's NATIVE_BINS * CHANNELS * MAX_BINNED_X * MAX_BINNED_Y *
// MAX_PLANES entries (262144 at the defaults), one entry a cycle, during which no
// request is taken; configuration writes are taken at any time. A finished result
// waits in the output register while the next request is taken; loading the next
// result waits until that register has been emptied.
`timescale 1ns / 1ps

module photon_lifetime_histogrammer_unit
  import plh_pkg::*;
#(
  parameter int NATIVE_BINS  = NATIVE_BINS_DEF,
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int MAX_BINNED_X = MAX_BINNED_X_DEF,
  parameter int MAX_BINNED_Y = MAX_BINNED_Y_DEF,
  parameter int MAX_PLANES   = MAX_PLANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  channel,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        plane,
  input  logic [11:0] arrival_time,
  input  logic        photon_valid,
  input  logic        frame_in_use,
  input  logic [7:0]  read_bin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] count_value,
  output logic [31:0] invalid_total,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int STORE_DEPTH = NATIVE_BINS * CHANNELS * MAX_BINNED_X * MAX_BINNED_Y
                               * MAX_PLANES;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int STRIDE_C    = NATIVE_BINS;
  localparam int STRIDE_X    = STRIDE_C * CHANNELS;
  localparam int STRIDE_Y    = STRIDE_X * MAX_BINNED_X;
  localparam int STRIDE_Z    = STRIDE_Y * MAX_BINNED_Y;
  localparam int DIV_CYCLES  = 9;
  localparam int DCW         = $clog2(DIV_CYCLES);
  localparam logic [3:0] CH_MASK = 4'((1 << CHANNELS) - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_EVAL, S_FETCH, S_UPDATE, S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [17:0] dq;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [15:0] d);
    logic [16:0] trial;
    logic        ge;
    div_lane_t   r;
    trial = {l.rem, l.dq[17]};
    ge    = trial >= {1'b0, d};
    r.rem = ge ? 16'(trial - {1'b0, d}) : trial[15:0];
    r.dq  = {l.dq[16:0], ge};
    return r;
  endfunction

  function automatic logic fits(logic [7:0] c, logic [8:0] size, logic [4:0] fa, int lim);
    logic [13:0] prod;
    prod = ({6'd0, c} + 14'd1) * {9'd0, fa};
    return (32'(c) < lim) && (prod <= {5'd0, size});
  endfunction

  // configuration
  logic [8:0]  sensor_width;
  logic [8:0]  sensor_height;
  logic        plane_count;
  logic [4:0]  spatial_bin_factor;
  logic [15:0] repetition_bins;
  logic [2:0]  downsample_shift;
  logic [3:0]  channel_enable_mask;
  logic [63:0] channel_time_shifts;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width        <= SENSOR_WIDTH_RST;
      sensor_height       <= SENSOR_HEIGHT_RST;
      plane_count         <= PLANE_COUNT_RST;
      spatial_bin_factor  <= BIN_FACTOR_RST;
      repetition_bins     <= '0;
      downsample_shift    <= '0;
      channel_enable_mask <= CHANNEL_MASK_RST;
      channel_time_shifts <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_WIDTH:  sensor_width        <= cfg_data[8:0];
        CFG_SENSOR_HEIGHT: sensor_height       <= cfg_data[8:0];
        CFG_PLANE_COUNT:   plane_count         <= cfg_data[0];
        CFG_BIN_FACTOR:    spatial_bin_factor  <= cfg_data[4:0];
        CFG_REPETITION:    repetition_bins     <= cfg_data[15:0];
        CFG_DOWNSAMPLE:    downsample_shift    <= cfg_data[2:0];
        CFG_CHANNEL_MASK:  channel_enable_mask <= cfg_data[3:0];
        CFG_TIME_SHIFTS:   channel_time_shifts <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic            clr_req;
  logic [DCW-1:0]  div_cnt;
  logic [31:0]     bad_bin_count;

  logic [1:0]  req_q;
  logic [1:0]  ch_q;
  logic [7:0]  px_q;
  logic [7:0]  py_q;
  logic        z_q;
  logic [11:0] mt_q;
  logic        pv_q;
  logic        fu_q;
  logic [7:0]  rb_q;
  logic        neg_q;
  div_lane_t   lx;
  div_lane_t   ly;
  div_lane_t   lt;
  logic [AW-1:0] addr;
  logic [2:0]  res_status;
  logic [15:0] res_count;

  logic [15:0] ram_rdata;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0] ram_wdata;
  logic        ram_re;

  // combinational evaluation
  logic [4:0]  fac;
  logic [3:0]  mask_eff;
  logic [15:0] sh_in;
  logic signed [17:0] t_sum;
  logic [17:0] t_mag;
  logic [9:0]  num_x;
  logic [9:0]  num_y;
  logic [15:0] div_xy;
  logic [1:0]  mc_ph;
  logic [2:0]  n_en;
  logic [15:0] s_mod;
  logic [15:0] b_full;
  logic [15:0] b_ds;
  logic [15:0] bin_total;
  logic        ph_reject;
  logic        ph_outside;
  logic        z_ok;
  logic        rd_bad;
  logic        is_photon;
  logic [7:0]  a_x;
  logic [7:0]  a_y;
  logic [1:0]  a_mc;
  logic [15:0] a_b;
  logic [AW-1:0] addr_calc;
  logic [15:0] count_inc;

  always_comb begin
    fac      = (spatial_bin_factor == 5'd0) ? 5'd1 : spatial_bin_factor;
    mask_eff = channel_enable_mask & CH_MASK;
    sh_in    = channel_time_shifts[16*channel +: 16];
    t_sum    = $signed({6'd0, arrival_time}) + $signed({{2{sh_in[15]}}, sh_in});
    t_mag    = t_sum[17] ? 18'(-t_sum) : 18'(t_sum);
    num_x    = {1'b0, pixel_x, 1'b0} + {5'd0, fac};
    num_y    = {1'b0, pixel_y, 1'b0} + {5'd0, fac};
    div_xy   = {10'd0, fac, 1'b0};

    mc_ph = '0;
    n_en  = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < ch_q) begin
        mc_ph = mc_ph + 2'(mask_eff[i]);
      end
      n_en = n_en + 3'(mask_eff[i]);
    end

    s_mod     = (neg_q && lt.rem != 16'd0) ? repetition_bins - lt.rem : lt.rem;
    b_full    = (repetition_bins == 16'd0) ? {4'd0, mt_q} : s_mod;
    b_ds      = b_full >> downsample_shift;
    bin_total = 16'(NATIVE_BINS) >> downsample_shift;

    is_photon  = req_q == REQ_PHOTON;
    z_ok       = (32'(z_q) < MAX_PLANES) && (z_q < plane_count);
    ph_reject  = !(pv_q && fu_q) || (32'(ch_q) >= CHANNELS) || !mask_eff[ch_q];
    ph_outside = ({1'b0, px_q} >= sensor_width) || ({1'b0, py_q} >= sensor_height)
                 || !fits(lx.dq[7:0], sensor_width, fac, MAX_BINNED_X)
                 || !fits(ly.dq[7:0], sensor_height, fac, MAX_BINNED_Y) || !z_ok;
    rd_bad     = ({1'b0, ch_q} >= n_en) || !fits(px_q, sensor_width, fac, MAX_BINNED_X)
                 || !fits(py_q, sensor_height, fac, MAX_BINNED_Y) || !z_ok
                 || ({8'd0, rb_q} >= bin_total);

    a_x  = is_photon ? lx.dq[7:0] : px_q;
    a_y  = is_photon ? ly.dq[7:0] : py_q;
    a_mc = is_photon ? mc_ph : ch_q;
    a_b  = is_photon ? b_ds : {8'd0, rb_q};
    addr_calc = AW'(z_q) * AW'(STRIDE_Z) + AW'(a_y) * AW'(STRIDE_Y)
                + AW'(a_x) * AW'(STRIDE_X) + AW'(a_mc) * AW'(STRIDE_C) + AW'(a_b);

    count_inc = (ram_rdata == 16'hffff) ? ram_rdata : ram_rdata + 16'd1;
  end

  assign in_ready  = state == S_IDLE;
  assign ram_we    = (state == S_CLEAR) || (state == S_UPDATE && is_photon);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == S_CLEAR) ? 16'd0 : count_inc;
  assign ram_re    = state == S_FETCH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_req       <= 1'b0;
      div_cnt       <= '0;
      bad_bin_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            clr_addr <= '0;
            if (clr_req) begin
              clr_req    <= 1'b0;
              res_status <= ST_OK;
              res_count  <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q  <= req_type;
            ch_q   <= channel;
            px_q   <= pixel_x;
            py_q   <= pixel_y;
            z_q    <= plane;
            mt_q   <= arrival_time;
            pv_q   <= photon_valid;
            fu_q   <= frame_in_use;
            rb_q   <= read_bin;
            neg_q  <= t_sum[17];
            lx     <= '{rem: 16'd0, dq: {8'd0, num_x}};
            ly     <= '{rem: 16'd0, dq: {8'd0, num_y}};
            lt     <= '{rem: 16'd0, dq: t_mag};
            div_cnt <= '0;
            case (req_type)
              REQ_PHOTON: state <= S_DIV;
              REQ_READ:   state <= S_EVAL;
              REQ_CLEAR: begin
                clr_req <= 1'b1;
                state   <= S_CLEAR;
              end
              default: begin
                res_status <= ST_REJECT;
                res_count  <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          lx      <= div_step(div_step(lx, div_xy), div_xy);
          ly      <= div_step(div_step(ly, div_xy), div_xy);
          lt      <= div_step(div_step(lt, repetition_bins), repetition_bins);
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIV_CYCLES - 1)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          addr      <= addr_calc;
          res_count <= '0;
          if (is_photon) begin
            if (ph_reject) begin
              res_status <= ST_REJECT;
              state      <= S_DONE;
            end else if (ph_outside) begin
              res_status <= ST_OUTSIDE;
              state      <= S_DONE;
            end else if (b_ds >= bin_total) begin
              if (bad_bin_count != 32'hffff_ffff) begin
                bad_bin_count <= bad_bin_count + 32'd1;
              end
              res_status <= ST_BAD_BIN;
              state      <= S_DONE;
            end else begin
              state <= S_FETCH;
            end
          end else if (rd_bad) begin
            res_status <= ST_BAD_READ;
            state      <= S_DONE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          res_status <= ST_OK;
          res_count  <= is_photon ? count_inc : ram_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            count_value   <= res_count;
            invalid_total <= bad_bin_count;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  plh_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  a_bad_bin_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> bad_bin_count >= $past(bad_bin_count))
    else $error("bad bin count went down");

  a_fail_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> count_value == 16'd0)
    else $error("failed request carries a count");

  a_incr_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE && is_photon |-> ram_wdata != 16'd0)
    else $error("counted photon wrote zero");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> state == S_CLEAR || $past(clr_addr) == AW'(STORE_DEPTH - 1))
    else $error("clearing pass left early");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("transfer taken without leaving idle");

endmodule

@@ tb/sv/plh_checker.sv @@
// Checker for the photon lifetime histogrammer: tracks settings, predicts every result, compares.
`timescale 1ns / 1ps

module plh_checker
  import plh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  channel,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        plane,
  input  logic [11:0] arrival_time,
  input  logic        photon_valid,
  input  logic        frame_in_use,
  input  logic [7:0]  read_bin,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] count_value,
  input  logic [31:0] invalid_total,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  localparam int NBINS = NATIVE_BINS_DEF;
  localparam int NCH   = CHANNELS_DEF;
  localparam int MAXX  = MAX_BINNED_X_DEF;
  localparam int MAXY  = MAX_BINNED_Y_DEF;
  localparam int MAXZ  = MAX_PLANES_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] count;
    logic [31:0] bad_total;
  } outcome_t;

  logic [8:0]  r_width;
  logic [8:0]  r_height;
  logic        r_planes;
  logic [4:0]  r_factor;
  logic [15:0] r_period;
  logic [2:0]  r_down;
  logic [3:0]  r_mask;
  logic [63:0] r_shifts;

  logic [15:0] bin_counts [int unsigned];
  logic [31:0] bad_bins;
  outcome_t    pending_results [$];
  int          fails = 0;

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 60) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Works out one result and updates the histogram and the bad-bin total.
  function automatic outcome_t histogram_update(
    input logic [1:0]  kind,
    input logic [1:0]  ch,
    input logic [7:0]  px,
    input logic [7:0]  py,
    input logic        z,
    input logic [11:0] mt,
    input logic        pv,
    input logic        fu,
    input logic [7:0]  rbin
  );
    outcome_t    res;
    int unsigned fac, bw, bh, zl, nbins, mc, nen, bx, by, tbin, addr, i;
    int          shift, period, wrapped;
    logic [15:0] cnt;
    res.status = ST_REJECT;
    res.count  = '0;
    fac = (r_factor == 0) ? 1 : r_factor;
    bw  = r_width / fac;
    if (bw > MAXX) bw = MAXX;
    bh  = r_height / fac;
    if (bh > MAXY) bh = MAXY;
    zl    = (r_planes < MAXZ) ? r_planes : MAXZ;
    nbins = NBINS >> r_down;
    mc  = 0;
    nen = 0;
    for (i = 0; i < NCH; i++) begin
      if (r_mask[i]) begin
        if (i < ch) mc++;
        nen++;
      end
    end
    case (kind)
      REQ_PHOTON: begin
        if (!(pv && fu) || ch >= NCH || !r_mask[ch]) begin
          res.status = ST_REJECT;
        end else if (px >= r_width || py >= r_height) begin
          res.status = ST_OUTSIDE;
        end else begin
          bx = (2 * px + fac) / (2 * fac);
          by = (2 * py + fac) / (2 * fac);
          if (bx >= bw || by >= bh || z >= zl) begin
            res.status = ST_OUTSIDE;
          end else begin
            tbin = mt;
            if (r_period != 0) begin
              shift   = $signed(r_shifts[16 * ch +: 16]);
              period  = r_period;
              wrapped = (int'(mt) + shift) % period;
              if (wrapped < 0) wrapped += period;
              tbin = wrapped;
            end
            tbin = tbin >> r_down;
            if (tbin >= nbins) begin
              res.status = ST_BAD_BIN;
              if (bad_bins != 32'hffff_ffff) bad_bins++;
            end else begin
              addr = (((z * MAXY + by) * MAXX + bx) * NCH + mc) * NBINS + tbin;
              cnt  = bin_counts.exists(addr) ? bin_counts[addr] : 16'd0;
              if (cnt != 16'hffff) cnt++;
              bin_counts[addr] = cnt;
              res.status = ST_OK;
              res.count  = cnt;
            end
          end
        end
      end
      REQ_CLEAR: begin
        bin_counts.delete();
        res.status = ST_OK;
      end
      REQ_READ: begin
        if (ch >= nen || px >= bw || py >= bh || z >= zl || rbin >= nbins) begin
          res.status = ST_BAD_READ;
        end else begin
          addr = (((z * MAXY + py) * MAXX + px) * NCH + ch) * NBINS + rbin;
          res.status = ST_OK;
          res.count  = bin_counts.exists(addr) ? bin_counts[addr] : 16'd0;
        end
      end
      default: res.status = ST_REJECT;
    endcase
    res.bad_total = bad_bins;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      r_width  = SENSOR_WIDTH_RST;
      r_height = SENSOR_HEIGHT_RST;
      r_planes = PLANE_COUNT_RST;
      r_factor = BIN_FACTOR_RST;
      r_period = '0;
      r_down   = '0;
      r_mask   = CHANNEL_MASK_RST;
      r_shifts = '0;
      bad_bins = '0;
      bin_counts.delete();
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (status %0d)",
                                    status));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (count_value !== want.count)
            report_mismatch($sformatf("count_value %0d, expected %0d", count_value,
                                      want.count));
          if (invalid_total !== want.bad_total)
            report_mismatch($sformatf("invalid_total %0d, expected %0d", invalid_total,
                                      want.bad_total));
        end
      end
      if (in_valid && in_ready)
        pending_results.insert(pending_results.size(),
                               histogram_update(req_type, channel, pixel_x, pixel_y,
                                                plane, arrival_time, photon_valid,
                                                frame_in_use, read_bin));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENSOR_WIDTH:  r_width  = cfg_data[8:0];
          CFG_SENSOR_HEIGHT: r_height = cfg_data[8:0];
          CFG_PLANE_COUNT:   r_planes = cfg_data[0];
          CFG_BIN_FACTOR:    r_factor = cfg_data[4:0];
          CFG_REPETITION:    r_period = cfg_data[15:0];
          CFG_DOWNSAMPLE:    r_down   = cfg_data[2:0];
          CFG_CHANNEL_MASK:  r_mask   = cfg_data[3:0];
          CFG_TIME_SHIFTS:   r_shifts = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= fails;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the photon lifetime histogrammer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import plh_pkg::*;

  localparam int          TIMEOUT_NS    = 25_000_000;
  localparam int          PHASES        = 10;
  localparam int          PHASE_ITEMS   = 38;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  ch;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        z;
    logic [11:0] mt;
    logic        pv;
    logic        fu;
    logic [7:0]  rbin;
  } request_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [1:0]  channel;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic        plane;
  logic [11:0] arrival_time;
  logic        photon_valid;
  logic        frame_in_use;
  logic [7:0]  read_bin;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [15:0] count_value;
  logic [31:0] invalid_total;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          outstanding;

  // Shadow of the settings, used only to shape stimulus.
  logic [8:0]  c_width;
  logic [8:0]  c_height;
  logic [4:0]  c_factor;
  logic [2:0]  c_down;
  logic [3:0]  c_mask;
  bit          steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  photon_lifetime_histogrammer_unit u_top (.*);
  plh_checker u_checker (.*);

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic request_t make_req(
    input logic [1:0] kind, input logic [1:0] ch, input logic [7:0] x, input logic [7:0] y,
    input logic z, input logic [11:0] mt, input logic pv, input logic fu,
    input logic [7:0] rbin
  );
    request_t r;
    r.kind = kind; r.ch = ch; r.x = x; r.y = y; r.z = z;
    r.mt = mt; r.pv = pv; r.fu = fu; r.rbin = rbin;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned fac, bw, bh, pop, sel;
    fac = (c_factor == 0) ? 1 : c_factor;
    bw  = c_width / fac;
    if (bw > MAX_BINNED_X_DEF) bw = MAX_BINNED_X_DEF;
    bh  = c_height / fac;
    if (bh > MAX_BINNED_Y_DEF) bh = MAX_BINNED_Y_DEF;
    pop = $countones(c_mask);
    sel = $urandom_range(0, 99);
    r = make_req(REQ_PHOTON, 2'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(0, 15) == 0, 12'($urandom), $urandom_range(0, 15) != 0,
                 $urandom_range(0, 15) != 0, 8'($urandom));
    if (sel < 3) begin
      r.kind = REQ_UNUSED;
    end else if (sel < 28) begin
      r.kind = REQ_READ;
      if ($urandom_range(0, 7) != 0) begin
        if (pop > 0) r.ch = 2'($urandom_range(0, pop - 1));
        if ($urandom_range(0, 1)) begin
          r.x    = 8'($urandom_range(0, 1));
          r.y    = 8'($urandom_range(0, 1));
          r.rbin = 8'($urandom_range(0, 3));
        end else begin
          r.x    = 8'($urandom_range(0, bw));
          r.y    = 8'($urandom_range(0, bh));
          r.rbin = 8'($urandom_range(0, (NATIVE_BINS_DEF >> c_down) - 1));
        end
      end
    end else if ($urandom_range(0, 7) != 0) begin
      // photon aimed at an enabled channel, a pixel inside the sensor and a sensible arrival time
      if (c_mask != 0) begin
        do r.ch = 2'($urandom_range(0, 3)); while (!c_mask[r.ch]);
      end
      if ($urandom_range(0, 1)) begin
        r.x  = 8'($urandom_range(0, 1));
        r.y  = 8'($urandom_range(0, 1));
        r.mt = 12'($urandom_range(0, 3));
      end else begin
        if (c_width != 0) r.x = 8'($urandom_range(0, c_width - 1));
        if (c_height != 0) r.y = 8'($urandom_range(0, c_height - 1));
        if ($urandom_range(0, 7) != 0) r.mt = 12'($urandom_range(0, 255));
      end
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    req_type     <= r.kind;
    channel      <= r.ch;
    pixel_x      <= r.x;
    pixel_y      <= r.y;
    plane        <= r.z;
    arrival_time <= r.mt;
    photon_valid <= r.pv;
    frame_in_use <= r.fu;
    read_bin     <= r.rbin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the request side until every result is back.
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_setting(
    input logic [8:0] w, input logic [8:0] h, input logic pc, input logic [4:0] f,
    input logic [15:0] rep, input logic [2:0] ds, input logic [3:0] mask,
    input logic [63:0] shifts
  );
    c_width  = w;
    c_height = h;
    c_factor = f;
    c_down   = ds;
    c_mask   = mask;
    write_reg(CFG_SENSOR_WIDTH, 64'(w));
    write_reg(CFG_SENSOR_HEIGHT, 64'(h));
    write_reg(CFG_PLANE_COUNT, 64'(pc));
    write_reg(CFG_BIN_FACTOR, 64'(f));
    write_reg(CFG_REPETITION, 64'(rep));
    write_reg(CFG_DOWNSAMPLE, 64'(ds));
    write_reg(CFG_CHANNEL_MASK, 64'(mask));
    write_reg(CFG_TIME_SHIFTS, shifts);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] random_shifts();
    logic [63:0] s;
    int          i;
    for (i = 0; i < 4; i++) begin
      if ($urandom_range(0, 1)) s[16 * i +: 16] = 16'($urandom_range(0, 600) - 300);
      else s[16 * i +: 16] = 16'($urandom);
    end
    return s;
  endfunction

  task automatic choose_setting(input int p);
    case (p)
      0: apply_setting(9'd16, 9'd16, 1'b1, 5'd1, 16'd0, 3'd0, 4'hf, 64'd0);
      1: apply_setting(9'd256, 9'd256, 1'b1, 5'd16, 16'hffff, 3'd7, 4'b1010,
                       {16'h7fff, 16'h8000, 16'h0001, 16'hffff});
      2: apply_setting(9'd0, 9'd1, 1'b0, 5'd0, 16'd1, 3'd3, 4'h0, random_shifts());
      3: apply_setting(9'd1, 9'd256, 1'b1, 5'd2, 16'd100, 3'd1, 4'b0001, {4{16'hfff0}});
      4: apply_setting(9'd200, 9'd37, 1'b1, 5'd0, 16'd300, 3'd2, 4'b0110, random_shifts());
      default: begin
        logic [8:0]  w, h;
        logic [4:0]  f;
        logic [15:0] rep;
        w = 9'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(8, 40));
        h = 9'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(8, 40));
        f = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 3));
        case ($urandom_range(0, 2))
          0: rep = 16'd0;
          1: rep = 16'($urandom_range(1, 400));
          default: rep = 16'($urandom_range(1, 65535));
        endcase
        apply_setting(w, h, $urandom_range(0, 7) != 0, f, rep, 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 7) == 0) ? 4'h0 : 4'($urandom_range(1, 15)),
                      random_shifts());
      end
    endcase
  endtask

  initial begin
    int p, n, hold_at, clear_at;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_PHOTON;
    channel      = '0;
    pixel_x      = '0;
    pixel_y      = '0;
    plane        = 1'b0;
    arrival_time = '0;
    photon_valid = 1'b0;
    frame_in_use = 1'b0;
    read_bin     = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SENSOR_WIDTH;
    cfg_data     = '0;
    c_width      = SENSOR_WIDTH_RST;
    c_height     = SENSOR_HEIGHT_RST;
    c_factor     = BIN_FACTOR_RST;
    c_down       = '0;
    c_mask       = CHANNEL_MASK_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed pass at the reset settings
    send_request(make_req(REQ_PHOTON, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd3, 8'd15, 8'd15, 1'b0, 12'd255, 1'b1, 1'b1, 8'd255));
    send_request(make_req(REQ_PHOTON, 2'd1, 8'd7, 8'd8, 1'b0, 12'd256, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd2, 8'd3, 8'd3, 1'b0, 12'd4095, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd1, 8'd1, 8'd1, 1'b0, 12'd5, 1'b0, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd1, 8'd1, 8'd1, 1'b0, 12'd5, 1'b1, 1'b0, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd2, 8'd16, 8'd0, 1'b0, 12'd5, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd2, 8'd255, 8'd255, 1'b0, 12'd5, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd0, 8'd2, 8'd2, 1'b1, 12'd5, 1'b1, 1'b1, 8'd0));
    send_request(make_req(REQ_READ, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_READ, 2'd3, 8'd15, 8'd15, 1'b0, 12'd0, 1'b0, 1'b0, 8'd255));
    send_request(make_req(REQ_READ, 2'd2, 8'd7, 8'd8, 1'b0, 12'd4095, 1'b1, 1'b1, 8'd128));
    send_request(make_req(REQ_READ, 2'd0, 8'd255, 8'd0, 1'b0, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_READ, 2'd0, 8'd0, 8'd16, 1'b0, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_READ, 2'd0, 8'd0, 8'd0, 1'b1, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_UNUSED, 2'd3, 8'd255, 8'd255, 1'b1, 12'd4095, 1'b1, 1'b1,
                          8'd255));
    send_request(make_req(REQ_CLEAR, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_READ, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b0, 1'b0, 8'd0));
    send_request(make_req(REQ_PHOTON, 2'd0, 8'd0, 8'd0, 1'b0, 12'd0, 1'b1, 1'b1, 8'd0));
    drain();

    for (p = 0; p < PHASES; p++) begin
      choose_setting(p);
      steady   = (p % 4 == 3);
      hold_at  = $urandom_range(5, PHASE_ITEMS - 5);
      clear_at = (p == 4) ? $urandom_range(10, PHASE_ITEMS - 5) : -1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == hold_at) drain();
        if (n == clear_at)
          send_request(make_req(REQ_CLEAR, 2'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                                8'($urandom)));
        else
          send_request(random_request());
      end
      drain();
    end

    steady = 1'b0;
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule
